// File: sv/prct_pkg.sv
// ----------------------------------------------------------------------------
// prct_pkg: shared types and constants of the page reference count table
// Request and result payloads, the internal command, operation and status
// codes, and the back end's state encoding.
// ----------------------------------------------------------------------------
package prct_pkg;

    localparam int ADDR_W      = 56;
    localparam int FIRST_W     = 36;
    localparam int END_W       = 37;
    localparam int COUNT_OUT_W = 8;
    localparam int IDX_MAX_W   = 20;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 4;

    localparam logic [FIRST_W-1:0] FIRST_PAGE_RESET = 36'd0;
    localparam logic [END_W-1:0]   END_PAGE_RESET   = 37'd32768;

    // Register select is address bit 3: registers sit at byte addresses 0 and 8.
    localparam logic REG_FIRST_PAGE = 1'b0;
    localparam logic REG_END_PAGE   = 1'b1;

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_SHARE    = 2'd1,
        OP_RELEASE  = 2'd2,
        OP_QUERY    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_BAD_ADDR   = 2'd1,
        STAT_AT_MAX     = 2'd2,
        STAT_NOT_IN_USE = 2'd3
    } t_status;

    typedef struct packed {
        t_op               operation;
        logic [ADDR_W-1:0] page_address;
    } t_req;

    typedef struct packed {
        t_status                status;
        logic [COUNT_OUT_W-1:0] count_after;
        logic                   page_freed;
        logic                   is_shared;
    } t_rsp;

    typedef struct packed {
        t_op                  op;
        logic                 bad;
        logic [IDX_MAX_W-1:0] idx;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'd0,
        BK_IDLE  = 2'd1,
        BK_EXEC  = 2'd2
    } t_back_state;

endpackage

// File: sv/prct_ram.sv
// ----------------------------------------------------------------------------
// prct_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module prct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/prct_front.sv
// ----------------------------------------------------------------------------
// prct_front: request intake and address check
// Checks alignment and range of each request, turns the page number into a
// table index and holds the classified commands in a two-entry queue.
// ----------------------------------------------------------------------------
module prct_front #(
    parameter int PAGE_BITS = 12,
    parameter int MAX_PAGES = 32768
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_enable,
    input  logic                          i_push,
    output logic                          o_full,
    input  prct_pkg::t_req                i_req,
    input  logic [prct_pkg::FIRST_W-1:0]  i_first_page,
    input  logic [prct_pkg::END_W-1:0]    i_end_page,
    output logic                          o_q_empty,
    output prct_pkg::t_cmd                o_q_head,
    input  logic                          i_q_pop
);

    localparam int PN_W  = prct_pkg::ADDR_W - PAGE_BITS;
    localparam int CMP_W = PN_W + 1;
    localparam int IW    = $clog2(MAX_PAGES);

    logic [PN_W-1:0]  page_num;
    logic [CMP_W-1:0] page_ext;
    logic [CMP_W-1:0] first_ext;
    logic [CMP_W-1:0] end_ext;
    logic [CMP_W-1:0] diff;
    logic             misaligned;
    prct_pkg::t_cmd   cmd;

    prct_pkg::t_cmd   r_q [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;
    logic             push_ok;
    logic             pop_ok;

    always_comb begin
        page_num   = i_req.page_address[prct_pkg::ADDR_W-1:PAGE_BITS];
        page_ext   = CMP_W'(page_num);
        first_ext  = CMP_W'(i_first_page);
        end_ext    = CMP_W'(i_end_page);
        diff       = page_ext - first_ext;
        misaligned = |i_req.page_address[PAGE_BITS-1:0];
        cmd.op     = i_req.operation;
        cmd.bad    = misaligned || (page_ext < first_ext) || (page_ext >= end_ext) ||
                     (diff >= CMP_W'(MAX_PAGES));
        cmd.idx    = prct_pkg::IDX_MAX_W'(diff[IW-1:0]);
    end

    assign o_full    = !i_enable || (r_count == 2'd2);
    assign push_ok   = i_push && !o_full;
    assign pop_ok    = i_q_pop && (r_count != 2'd0);
    assign o_q_empty = (r_count == 2'd0);
    assign o_q_head  = r_q[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 2'd1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push_ok) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (r_count <= 2'd2))
        else $error("command queue holds more than two entries");

    a_no_push_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_enable |-> !push_ok)
        else $error("request taken while the table is being cleared");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_ok && !pop_ok) |=> (r_count == $past(r_count) + 2'd1))
        else $error("queue count did not grow on a lone push");
`endif

endmodule

// File: sv/prct_back.sv
// ----------------------------------------------------------------------------
// prct_back: counter update engine
// Clears the count table after reset, then reads and updates one count per
// command, writes back changes and places each result in the output register.
// ----------------------------------------------------------------------------
module prct_back #(
    parameter int MAX_PAGES   = 32768,
    parameter int COUNT_WIDTH = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    output logic           o_ready,
    input  logic           i_q_empty,
    input  prct_pkg::t_cmd i_q_head,
    output logic           o_q_pop,
    output logic           o_empty,
    input  logic           i_pop,
    output prct_pkg::t_rsp o_rsp
);

    localparam int IW = $clog2(MAX_PAGES);
    localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

    prct_pkg::t_back_state r_state;
    prct_pkg::t_back_state n_state;
    logic [IW-1:0]         r_clr_addr;
    logic [IW-1:0]         n_clr_addr;
    prct_pkg::t_cmd        r_cmd;
    logic                  r_out_valid;
    logic                  n_out_valid;
    prct_pkg::t_rsp        r_rsp;
    prct_pkg::t_rsp        n_rsp;
    logic                  out_load;

    logic                   ram_we;
    logic [IW-1:0]          ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic [COUNT_WIDTH-1:0] rdata;

    prct_pkg::t_status      res_status;
    logic [COUNT_WIDTH-1:0] res_cnt;
    logic                   res_freed;
    logic                   wr_need;

    prct_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (MAX_PAGES)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (o_q_pop),
        .i_raddr (i_q_head.idx[IW-1:0]),
        .o_rdata (rdata)
    );

    // Outcome of the command held in r_cmd, given the count just read.
    always_comb begin
        res_status = prct_pkg::STAT_OK;
        res_cnt    = '0;
        res_freed  = 1'b0;
        wr_need    = 1'b0;
        if (r_cmd.bad) begin
            res_status = prct_pkg::STAT_BAD_ADDR;
        end else begin
            case (r_cmd.op)
                prct_pkg::OP_REGISTER: begin
                    res_cnt = COUNT_WIDTH'(1);
                    wr_need = 1'b1;
                end
                prct_pkg::OP_SHARE: begin
                    if (rdata == CMAX) begin
                        res_status = prct_pkg::STAT_AT_MAX;
                        res_cnt    = rdata;
                    end else if (rdata == '0) begin
                        res_status = prct_pkg::STAT_NOT_IN_USE;
                    end else begin
                        res_cnt = rdata + COUNT_WIDTH'(1);
                        wr_need = 1'b1;
                    end
                end
                prct_pkg::OP_RELEASE: begin
                    if (rdata == '0) begin
                        res_status = prct_pkg::STAT_NOT_IN_USE;
                    end else begin
                        res_cnt   = rdata - COUNT_WIDTH'(1);
                        res_freed = (rdata == COUNT_WIDTH'(1));
                        wr_need   = 1'b1;
                    end
                end
                prct_pkg::OP_QUERY: begin
                    res_cnt = rdata;
                end
                default: begin
                    res_cnt = rdata;
                end
            endcase
        end
        n_rsp.status      = res_status;
        n_rsp.count_after = prct_pkg::COUNT_OUT_W'(res_cnt);
        n_rsp.page_freed  = res_freed;
        n_rsp.is_shared   = (res_cnt > COUNT_WIDTH'(1));
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        ram_we     = 1'b0;
        ram_waddr  = r_cmd.idx[IW-1:0];
        ram_wdata  = res_cnt;
        o_q_pop    = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            prct_pkg::BK_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + IW'(1);
                if (r_clr_addr == IW'(MAX_PAGES - 1)) begin
                    n_state = prct_pkg::BK_IDLE;
                end
            end
            prct_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = prct_pkg::BK_EXEC;
                end
            end
            prct_pkg::BK_EXEC: begin
                if (!r_out_valid || i_pop) begin
                    out_load = 1'b1;
                    ram_we   = wr_need;
                    n_state  = prct_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = prct_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prct_pkg::BK_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_head;
        end
        if (out_load) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_ready = (r_state != prct_pkg::BK_CLEAR);
    assign o_empty = !r_out_valid;
    assign o_rsp   = r_rsp;

`ifndef ASSERT_OFF
    a_clear_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == prct_pkg::BK_CLEAR) |-> !o_q_pop)
        else $error("command taken before the table was cleared");

    a_bad_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == prct_pkg::BK_EXEC && r_cmd.bad) |-> !ram_we)
        else $error("count written for a bad address");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |-> !out_load)
        else $error("waiting result overwritten");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_cmd.bad) |-> (n_rsp.count_after == '0 && !n_rsp.page_freed))
        else $error("bad address result carries a count");
`endif

endmodule

// File: sv/page_reference_count_table.sv
// ----------------------------------------------------------------------------
// page_reference_count_table: per-page reference counters
// Register, share, release and query requests on a table of page counts.
// ----------------------------------------------------------------------------
// After reset the block clears its count table, one entry a cycle; full stays
// high during that pass. Afterwards each request reads its count from the
// count memory, then updates it and writes it back if it changed. The back
// end takes one command at a time and holds it while an earlier result
// waits to be popped. A request passes from the command queue into the
// command register while its count is read, and its result into the
// output register. A two-entry command queue lets requests be taken while a
// result waits to be popped. first_page sits at byte address 0, end_page at 8.
module page_reference_count_table #(
    parameter int PAGE_BITS   = 12,
    parameter int MAX_PAGES   = 32768,
    parameter int COUNT_WIDTH = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [prct_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [prct_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [prct_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    input  logic                             push,
    output logic                             full,
    input  prct_pkg::t_req                   i_req,
    output logic                             empty,
    input  logic                             pop,
    output prct_pkg::t_rsp                   o_rsp
);

    logic [prct_pkg::FIRST_W-1:0] r_first_page;
    logic [prct_pkg::END_W-1:0]   r_end_page;
    logic                         cfg_write;
    logic                         back_ready;
    logic                         q_empty;
    logic                         q_pop;
    prct_pkg::t_cmd               q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_page <= prct_pkg::FIRST_PAGE_RESET;
            r_end_page   <= prct_pkg::END_PAGE_RESET;
        end else if (cfg_write) begin
            if (paddr[3] == prct_pkg::REG_FIRST_PAGE) begin
                r_first_page <= pwdata[prct_pkg::FIRST_W-1:0];
            end else begin
                r_end_page <= pwdata[prct_pkg::END_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[3] == prct_pkg::REG_END_PAGE) begin
            prdata = prct_pkg::CFG_DATA_W'(r_end_page);
        end else begin
            prdata = prct_pkg::CFG_DATA_W'(r_first_page);
        end
    end

    prct_front #(
        .PAGE_BITS (PAGE_BITS),
        .MAX_PAGES (MAX_PAGES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_enable     (back_ready),
        .i_push       (push),
        .o_full       (full),
        .i_req        (i_req),
        .i_first_page (r_first_page),
        .i_end_page   (r_end_page),
        .o_q_empty    (q_empty),
        .o_q_head     (q_head),
        .i_q_pop      (q_pop)
    );

    prct_back #(
        .MAX_PAGES   (MAX_PAGES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_ready   (back_ready),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_rsp     (o_rsp)
    );

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for page_reference_count_table
// Requests go in through a push/full queue port and results come back through
// an empty/pop port, both sides with random idle gaps. A predictor keeps its
// own copy of the count table and the page window, and every result is checked
// field by field in arrival order. The window registers are changed between
// phases, always with the block idle, and each write is read back.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         PAGE_SHIFT   = 12;
    localparam int         TABLE_PAGES  = 32768;
    localparam logic [7:0] COUNT_TOP    = 8'hFF;
    localparam int         POOL_N       = 8;
    localparam int         IDLE_LIMIT   = 200000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         HOLD_AT      = 350;
    localparam int         HOLD_CYCLES  = 300;

    logic                            i_clk   = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [prct_pkg::CFG_ADDR_W-1:0] paddr   = '0;
    logic [prct_pkg::CFG_DATA_W-1:0] pwdata  = '0;
    logic [prct_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            push    = 1'b0;
    logic                            full;
    prct_pkg::t_req                  i_req   = '0;
    logic                            empty;
    logic                            pop     = 1'b0;
    prct_pkg::t_rsp                  o_rsp;

    // Predictor state: count table and page window.
    logic [7:0]                   count_mirror [TABLE_PAGES];
    logic [prct_pkg::FIRST_W-1:0] first_pg = prct_pkg::FIRST_PAGE_RESET;
    logic [prct_pkg::END_W-1:0]   end_pg   = prct_pkg::END_PAGE_RESET;

    logic [63:0] win_first;
    int          win_size;
    logic [63:0] page_pool [POOL_N];

    prct_pkg::t_req pend_reqs [$];
    prct_pkg::t_rsp rsp_expected [$];
    prct_pkg::t_rsp req_rsp;
    prct_pkg::t_rsp rsp_want;

    int send_gap    = 0;
    int send_burst  = 0;
    int recv_hold   = 0;
    int recv_burst  = 0;
    int stall_count = 0;
    int n_req       = 0;
    int n_rsp       = 0;
    int n_cfg       = 0;
    int n_fail      = 0;
    int n_bad       = 0;
    int n_atmax     = 0;
    int n_notuse    = 0;
    int n_freed     = 0;

    page_reference_count_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .push    (push),
        .full    (full),
        .i_req   (i_req),
        .empty   (empty),
        .pop     (pop),
        .o_rsp   (o_rsp)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic prct_pkg::t_rsp predict_count(prct_pkg::t_req rq);
        logic [63:0]    page;
        logic [63:0]    idx;
        logic [7:0]     cnt;
        prct_pkg::t_rsp r;
        r = '0;
        page = {20'd0, rq.page_address[prct_pkg::ADDR_W-1:PAGE_SHIFT]};
        if (rq.page_address[PAGE_SHIFT-1:0] != '0 || page < first_pg || page >= end_pg ||
            page - first_pg >= 64'(TABLE_PAGES)) begin
            r.status = prct_pkg::STAT_BAD_ADDR;
            return r;
        end
        idx = page - first_pg;
        cnt = count_mirror[idx[14:0]];
        case (rq.operation)
            prct_pkg::OP_REGISTER: begin
                count_mirror[idx[14:0]] = 8'd1;
                r.count_after = 8'd1;
            end
            prct_pkg::OP_SHARE: begin
                if (cnt == COUNT_TOP) begin
                    r.status = prct_pkg::STAT_AT_MAX;
                    r.count_after = cnt;
                end else if (cnt == 8'd0) begin
                    r.status = prct_pkg::STAT_NOT_IN_USE;
                end else begin
                    count_mirror[idx[14:0]] = cnt + 8'd1;
                    r.count_after = cnt + 8'd1;
                end
            end
            prct_pkg::OP_RELEASE: begin
                if (cnt == 8'd0) begin
                    r.status = prct_pkg::STAT_NOT_IN_USE;
                end else begin
                    count_mirror[idx[14:0]] = cnt - 8'd1;
                    r.count_after = cnt - 8'd1;
                    r.page_freed = (cnt == 8'd1);
                end
            end
            default: begin
                r.count_after = cnt;
            end
        endcase
        r.is_shared = (r.count_after > 8'd1);
        return r;
    endfunction

    // Random wait before the next item, with occasional runs of back-to-back items.
    function automatic int draw_wait(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [63:0] pg_addr(logic [63:0] page);
        return page << PAGE_SHIFT;
    endfunction

    function automatic prct_pkg::t_req make_req(prct_pkg::t_op op, logic [63:0] addr);
        prct_pkg::t_req rq;
        rq.operation = op;
        rq.page_address = addr[prct_pkg::ADDR_W-1:0];
        return rq;
    endfunction

    // Most requests hit a small pool of managed pages so that counts build up
    // and fall; the rest are misaligned, out of the window or fully random.
    function automatic prct_pkg::t_req random_request();
        logic [63:0]   page;
        logic [63:0]   addr;
        int            pick;
        int            w;
        prct_pkg::t_op op;
        pick = $urandom_range(0, 99);
        w = $urandom_range(0, 99);
        if (w < 15) op = prct_pkg::OP_REGISTER;
        else if (w < 55) op = prct_pkg::OP_SHARE;
        else if (w < 85) op = prct_pkg::OP_RELEASE;
        else op = prct_pkg::OP_QUERY;
        if (win_size == 0 || pick >= 91) begin
            addr = {$urandom, $urandom};
        end else begin
            page = win_first + page_pool[$urandom_range(0, POOL_N - 1)];
            if (pick >= 83) begin
                case ($urandom_range(0, 3))
                    0: page = win_first - 64'd1 - 64'($urandom_range(0, 3));
                    1: page = 64'(end_pg) + 64'($urandom_range(0, 3));
                    2: page = win_first + 64'(TABLE_PAGES) + 64'($urandom_range(0, 3));
                    default: page = {$urandom, $urandom};
                endcase
            end
            addr = pg_addr(page);
            if (pick >= 75 && pick < 83) begin
                addr[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom_range(1, 4095));
            end
        end
        return make_req(op, addr);
    endfunction

    task automatic set_window();
        logic [63:0] span;
        win_first = 64'(first_pg);
        span = (end_pg > first_pg) ? 64'(end_pg) - 64'(first_pg) : 64'd0;
        win_size = (span > 64'(TABLE_PAGES)) ? TABLE_PAGES : int'(span);
        if (win_size > 0) begin
            page_pool[0] = 64'd0;
            page_pool[1] = 64'(win_size - 1);
            for (int i = 2; i < POOL_N; i++) begin
                page_pool[i] = 64'($urandom_range(0, win_size - 1));
            end
        end
    endtask

    task automatic wait_idle();
        while (pend_reqs.size() != 0 || push || rsp_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic reg_sel, input logic [63:0] value);
        logic [prct_pkg::CFG_DATA_W-1:0] got;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // Read the register back with a second transfer.
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        n_cfg++;
        if (reg_sel == prct_pkg::REG_FIRST_PAGE) begin
            first_pg = value[prct_pkg::FIRST_W-1:0];
            if (got[prct_pkg::FIRST_W-1:0] !== first_pg) begin
                $error("first_page: expected %0h, got %0h", first_pg,
                       got[prct_pkg::FIRST_W-1:0]);
                n_fail++;
            end
        end else begin
            end_pg = value[prct_pkg::END_W-1:0];
            if (got[prct_pkg::END_W-1:0] !== end_pg) begin
                $error("end_page: expected %0h, got %0h", end_pg,
                       got[prct_pkg::END_W-1:0]);
                n_fail++;
            end
        end
    endtask

    task automatic run_phase(input logic [63:0] first, input logic [63:0] last, input int n);
        wait_idle();
        cfg_write(prct_pkg::REG_FIRST_PAGE, first);
        cfg_write(prct_pkg::REG_END_PAGE, last);
        set_window();
        repeat (n) pend_reqs.push_back(random_request());
    endtask

    // Sender: predicts each request as it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!(push && full)) begin
            if (push) begin
                req_rsp = predict_count(i_req);
                rsp_expected.push_back(req_rsp);
                n_req++;
                if (req_rsp.status == prct_pkg::STAT_BAD_ADDR) n_bad++;
                if (req_rsp.status == prct_pkg::STAT_AT_MAX) n_atmax++;
                if (req_rsp.status == prct_pkg::STAT_NOT_IN_USE) n_notuse++;
                if (req_rsp.page_freed) n_freed++;
                send_gap = draw_wait(send_burst);
            end
            if (send_gap != 0) begin
                send_gap--;
                push <= 1'b0;
            end else if (pend_reqs.size() != 0) begin
                push  <= 1'b1;
                i_req <= pend_reqs.pop_front();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Receiver: checks each result against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (rsp_expected.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    n_fail++;
                end else begin
                    rsp_want = rsp_expected.pop_front();
                    if (o_rsp.status !== rsp_want.status) begin
                        $error("status: expected %0d, got %0d", rsp_want.status, o_rsp.status);
                        n_fail++;
                    end
                    if (o_rsp.count_after !== rsp_want.count_after) begin
                        $error("count_after: expected %0d, got %0d",
                               rsp_want.count_after, o_rsp.count_after);
                        n_fail++;
                    end
                    if (o_rsp.page_freed !== rsp_want.page_freed) begin
                        $error("page_freed: expected %0d, got %0d",
                               rsp_want.page_freed, o_rsp.page_freed);
                        n_fail++;
                    end
                    if (o_rsp.is_shared !== rsp_want.is_shared) begin
                        $error("is_shared: expected %0d, got %0d",
                               rsp_want.is_shared, o_rsp.is_shared);
                        n_fail++;
                    end
                end
                n_rsp++;
                // One long hold-off lets the block fill up and push back.
                if (n_rsp == HOLD_AT) recv_hold = HOLD_CYCLES;
                else recv_hold = draw_wait(recv_burst);
            end
            if (recv_hold != 0) begin
                recv_hold--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog: the clearing pass after reset is the longest quiet stretch.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || psel) stall_count <= 0;
        else stall_count <= stall_count + 1;
        if (stall_count >= IDLE_LIMIT) begin
            $display("** page_reference_count_table: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [63:0] rnd_first;
        foreach (count_mirror[i]) count_mirror[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Free page, register, share, re-register and release to zero.
        pend_reqs.push_back(make_req(prct_pkg::OP_QUERY,    pg_addr(64'd5)));
        pend_reqs.push_back(make_req(prct_pkg::OP_SHARE,    pg_addr(64'd5)));
        pend_reqs.push_back(make_req(prct_pkg::OP_RELEASE,  pg_addr(64'd5)));
        pend_reqs.push_back(make_req(prct_pkg::OP_REGISTER, pg_addr(64'd5)));
        pend_reqs.push_back(make_req(prct_pkg::OP_SHARE,    pg_addr(64'd5)));
        pend_reqs.push_back(make_req(prct_pkg::OP_QUERY,    pg_addr(64'd5)));
        pend_reqs.push_back(make_req(prct_pkg::OP_REGISTER, pg_addr(64'd5)));
        pend_reqs.push_back(make_req(prct_pkg::OP_RELEASE,  pg_addr(64'd5)));
        pend_reqs.push_back(make_req(prct_pkg::OP_RELEASE,  pg_addr(64'd5)));
        // Edges of the window and bad addresses.
        pend_reqs.push_back(make_req(prct_pkg::OP_REGISTER, 64'd0));
        pend_reqs.push_back(make_req(prct_pkg::OP_REGISTER, pg_addr(64'(TABLE_PAGES - 1))));
        pend_reqs.push_back(make_req(prct_pkg::OP_RELEASE,  pg_addr(64'(TABLE_PAGES - 1))));
        pend_reqs.push_back(make_req(prct_pkg::OP_REGISTER, pg_addr(64'(TABLE_PAGES))));
        pend_reqs.push_back(make_req(prct_pkg::OP_REGISTER, 64'h5001));
        pend_reqs.push_back(make_req(prct_pkg::OP_QUERY,    {64{1'b1}}));
        pend_reqs.push_back(make_req(prct_pkg::OP_SHARE,    {64{1'b1}}));
        pend_reqs.push_back(make_req(prct_pkg::OP_RELEASE,  64'hFFF));
        pend_reqs.push_back(make_req(prct_pkg::OP_SHARE,    64'd0));
        pend_reqs.push_back(make_req(prct_pkg::OP_QUERY,    64'd0));
        pend_reqs.push_back(make_req(prct_pkg::OP_RELEASE,  64'd0));
        pend_reqs.push_back(make_req(prct_pkg::OP_RELEASE,  64'd0));

        // Drive one page to the top count and past it.
        pend_reqs.push_back(make_req(prct_pkg::OP_REGISTER, pg_addr(64'd77)));
        repeat (256) pend_reqs.push_back(make_req(prct_pkg::OP_SHARE, pg_addr(64'd77)));
        pend_reqs.push_back(make_req(prct_pkg::OP_QUERY,   pg_addr(64'd77)));
        pend_reqs.push_back(make_req(prct_pkg::OP_RELEASE, pg_addr(64'd77)));

        set_window();
        repeat (200) pend_reqs.push_back(random_request());

        run_phase(64'h1000, 64'h1040, 220);
        run_phase(64'd0, 64'h10_0000_0000, 220);
        run_phase(64'hF_FFFF_FFFF, 64'h10_0000_0000, 180);
        run_phase(64'd500, 64'd0, 80);
        rnd_first = {$urandom, $urandom} % (64'h10_0000_0000 - 64'd40000);
        run_phase(rnd_first, rnd_first + 64'($urandom_range(1, 40000)), 220);
        run_phase(64'd0, 64'd32768, 200);
        wait_idle();

        $display("Ran %0d requests and checked %0d results across %0d register writes.",
                 n_req, n_rsp, n_cfg);
        $display("Seen: %0d bad address, %0d at maximum, %0d not in use, %0d pages freed.",
                 n_bad, n_atmax, n_notuse, n_freed);
        if (n_fail == 0) begin
            $display("** page_reference_count_table: PASSED **");
        end else begin
            $display("** page_reference_count_table: FAILED **");
        end
        $finish;
    end

endmodule
